FILE: hdl/macs_pkg.sv
// Shared types and constants for the motor ADC settle calibration sequencer.
// Used by the history cells, the sequencer, the top level and the port checker.
package macs_pkg;

  localparam int SAMPLE_BITS   = 12;
  localparam int HISTORY_DEPTH = 4;
  localparam int COUNT_BITS    = 16;

  // configuration register indexes
  localparam logic [1:0] CFG_CHANNEL_SELECT = 2'd0;
  localparam logic [1:0] CFG_PRECISION_MASK = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT_TICKS  = 2'd2;

  // configuration reset values
  localparam logic [3:0]            CHANNEL_SELECT_RST = 4'd3;
  localparam logic [SAMPLE_BITS-1:0] PRECISION_MASK_RST = 12'd4092;
  localparam logic [COUNT_BITS-1:0]  TIMEOUT_TICKS_RST  = 16'd1000;

  // valid channel window: 3 .. 6 select inputs one to four
  localparam logic [3:0] CHANNEL_FIRST = 4'd3;
  localparam logic [3:0] CHANNEL_LAST  = 4'd6;

  // command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // drive request codes
  localparam logic [1:0] DRIVE_NONE = 2'd0;
  localparam logic [1:0] DRIVE_UP   = 2'd1;
  localparam logic [1:0] DRIVE_DOWN = 2'd2;

  // external phase codes
  localparam logic [3:0] PHASE_CODE_START   = 4'd0;
  localparam logic [3:0] PHASE_CODE_ARM_UP  = 4'd1;
  localparam logic [3:0] PHASE_CODE_DRV_UP  = 4'd2;
  localparam logic [3:0] PHASE_CODE_WAIT_UP = 4'd3;
  localparam logic [3:0] PHASE_CODE_CAP_UP  = 4'd4;
  localparam logic [3:0] PHASE_CODE_ARM_DN  = 4'd5;
  localparam logic [3:0] PHASE_CODE_DRV_DN  = 4'd6;
  localparam logic [3:0] PHASE_CODE_WAIT_DN = 4'd7;
  localparam logic [3:0] PHASE_CODE_CAP_DN  = 4'd8;
  localparam logic [3:0] PHASE_CODE_SETTLE  = 4'd9;
  localparam logic [3:0] PHASE_CODE_FINISH  = 4'd10;
  localparam logic [3:0] PHASE_CODE_IDLE    = 4'd11;

  typedef enum logic [11:0] {
    PH_START   = 12'b0000_0000_0001,
    PH_ARM_UP  = 12'b0000_0000_0010,
    PH_DRV_UP  = 12'b0000_0000_0100,
    PH_WAIT_UP = 12'b0000_0000_1000,
    PH_CAP_UP  = 12'b0000_0001_0000,
    PH_ARM_DN  = 12'b0000_0010_0000,
    PH_DRV_DN  = 12'b0000_0100_0000,
    PH_WAIT_DN = 12'b0000_1000_0000,
    PH_CAP_DN  = 12'b0001_0000_0000,
    PH_SETTLE  = 12'b0010_0000_0000,
    PH_FINISH  = 12'b0100_0000_0000,
    PH_IDLE    = 12'b1000_0000_0000
  } phase_t;

  typedef struct packed {
    logic                   command;
    logic [SAMPLE_BITS-1:0] adc_in_one;
    logic [SAMPLE_BITS-1:0] adc_in_two;
    logic [SAMPLE_BITS-1:0] adc_in_three;
    logic [SAMPLE_BITS-1:0] adc_in_four;
  } in_beat_t;

  typedef struct packed {
    logic [3:0]             phase_code;
    logic [1:0]             drive_request;
    logic [SAMPLE_BITS-1:0] reading_up;
    logic [SAMPLE_BITS-1:0] reading_down;
    logic                   done_res;
    logic                   timeout_flag;
    logic                   channel_error;
  } out_beat_t;

  // control from the sequencer to every history cell
  typedef struct packed {
    logic                   clear;    // zero all entries
    logic                   home;     // write pointer back to entry zero
    logic                   advance;  // pass the write token to the next cell
    logic                   write;    // token holder stores the sample
    logic [SAMPLE_BITS-1:0] sample;
  } hist_ctl_t;

  function automatic logic [3:0] phase_code(phase_t ph);
    logic [3:0] code;
    unique case (ph)
      PH_START:   code = PHASE_CODE_START;
      PH_ARM_UP:  code = PHASE_CODE_ARM_UP;
      PH_DRV_UP:  code = PHASE_CODE_DRV_UP;
      PH_WAIT_UP: code = PHASE_CODE_WAIT_UP;
      PH_CAP_UP:  code = PHASE_CODE_CAP_UP;
      PH_ARM_DN:  code = PHASE_CODE_ARM_DN;
      PH_DRV_DN:  code = PHASE_CODE_DRV_DN;
      PH_WAIT_DN: code = PHASE_CODE_WAIT_DN;
      PH_CAP_DN:  code = PHASE_CODE_CAP_DN;
      PH_SETTLE:  code = PHASE_CODE_SETTLE;
      PH_FINISH:  code = PHASE_CODE_FINISH;
      default:    code = PHASE_CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

FILE: hdl/macs_hist_cell.sv
// One entry of the sample history ring: holds a sample and a share of the
// write token, and extends the settle compare chain. Depends on macs_pkg.
module macs_hist_cell #(
  parameter bit HOME = 1'b0
) (
  input  logic                            clk,
  input  logic                            rst,
  input  macs_pkg::hist_ctl_t             ctl,
  input  logic [macs_pkg::SAMPLE_BITS-1:0] mask,
  input  logic                            token_in,
  input  logic [macs_pkg::SAMPLE_BITS-1:0] ref_in,
  input  logic                            eq_in,
  output logic                            token,
  output logic [macs_pkg::SAMPLE_BITS-1:0] mval,
  output logic                            eq_out
);

  logic [macs_pkg::SAMPLE_BITS-1:0] value;
  logic [macs_pkg::SAMPLE_BITS-1:0] value_next;
  logic                             token_next;

  always_comb begin
    priority if (ctl.clear) begin
      value_next = '0;
    end else if (ctl.write && token) begin
      value_next = ctl.sample;
    end else begin
      value_next = value;
    end
  end

  always_comb begin
    priority if (ctl.home) begin
      token_next = HOME;
    end else if (ctl.advance) begin
      token_next = token_in;
    end else begin
      token_next = token;
    end
  end

  // compare against the post-write contents, as the step decides on them
  assign mval   = value_next & mask;
  assign eq_out = eq_in && (mval == ref_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
      token <= HOME;
    end else begin
      value <= value_next;
      token <= token_next;
    end
  end

endmodule

FILE: hdl/macs_seq.sv
// Phase sequencer: tick counter, captured readings and status flags; drives
// the history cells and forms the result beat. Depends on macs_pkg.
module macs_seq (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             step,
  input  macs_pkg::in_beat_t               beat,
  input  logic [3:0]                       channel_select,
  input  logic [macs_pkg::COUNT_BITS-1:0]  timeout_ticks,
  input  logic                             settled,
  output macs_pkg::hist_ctl_t              ctl,
  output macs_pkg::out_beat_t              result
);

  macs_pkg::phase_t                 phase, phase_next, nxt;
  logic [macs_pkg::COUNT_BITS-1:0]  tick_count, tick_next, tick_inc;
  logic [macs_pkg::SAMPLE_BITS-1:0] captured_up, captured_up_next;
  logic [macs_pkg::SAMPLE_BITS-1:0] captured_down, captured_down_next;
  logic                             timed_out, timed_out_next;
  logic                             channel_fault, channel_fault_next;
  logic                             finished, finished_next;
  logic [1:0]                       drive;
  logic                             chan_ok;
  logic [1:0]                       chan_idx;
  logic [macs_pkg::SAMPLE_BITS-1:0] sample;
  logic                             expired;
  logic                             working;

  assign chan_ok  = (channel_select >= macs_pkg::CHANNEL_FIRST) &&
                    (channel_select <= macs_pkg::CHANNEL_LAST);
  assign chan_idx = 2'(channel_select - macs_pkg::CHANNEL_FIRST);

  always_comb begin
    unique case (chan_idx)
      2'd0:    sample = beat.adc_in_one;
      2'd1:    sample = beat.adc_in_two;
      2'd2:    sample = beat.adc_in_three;
      default: sample = beat.adc_in_four;
    endcase
  end

  // saturating count
  assign tick_inc = (tick_count == '1) ? tick_count : tick_count + 1'b1;
  assign expired  = tick_inc >= timeout_ticks;
  assign working  = (phase != macs_pkg::PH_FINISH) && (phase != macs_pkg::PH_IDLE);

  always_comb begin
    phase_next         = phase;
    nxt                = phase;
    tick_next          = tick_count;
    captured_up_next   = captured_up;
    captured_down_next = captured_down;
    timed_out_next     = timed_out;
    channel_fault_next = channel_fault;
    finished_next      = finished;
    drive              = macs_pkg::DRIVE_NONE;
    ctl                = '0;
    ctl.sample         = sample;

    if (step) begin
      priority if (beat.command == macs_pkg::CMD_START) begin
        phase_next         = macs_pkg::PH_START;
        tick_next          = '0;
        finished_next      = 1'b0;
        timed_out_next     = 1'b0;
        channel_fault_next = 1'b0;
        ctl.clear          = 1'b1;
        ctl.home           = 1'b1;
      end else if (phase == macs_pkg::PH_FINISH) begin
        finished_next = 1'b1;
        phase_next    = macs_pkg::PH_IDLE;
      end else if (working) begin
        tick_next = tick_inc;
        if (expired) begin
          timed_out_next = 1'b1;
        end
        unique case (phase)
          macs_pkg::PH_START: begin
            ctl.clear     = 1'b1;
            finished_next = 1'b0;
            nxt           = macs_pkg::PH_ARM_UP;
          end
          macs_pkg::PH_ARM_UP: begin
            tick_next     = '0;
            ctl.home      = 1'b1;
            finished_next = 1'b0;
            nxt           = macs_pkg::PH_DRV_UP;
          end
          macs_pkg::PH_DRV_UP: begin
            drive = macs_pkg::DRIVE_UP;
            nxt   = macs_pkg::PH_WAIT_UP;
          end
          macs_pkg::PH_WAIT_UP: begin
            ctl.write   = chan_ok;
            ctl.advance = 1'b1;
            if (!chan_ok) begin
              channel_fault_next = 1'b1;
            end
            nxt = settled ? macs_pkg::PH_CAP_UP : macs_pkg::PH_WAIT_UP;
          end
          macs_pkg::PH_CAP_UP: begin
            if (chan_ok) begin
              captured_up_next = sample;
            end else begin
              channel_fault_next = 1'b1;
            end
            nxt = macs_pkg::PH_ARM_DN;
          end
          macs_pkg::PH_ARM_DN: begin
            tick_next     = '0;
            ctl.home      = 1'b1;
            finished_next = 1'b0;
            nxt           = macs_pkg::PH_DRV_DN;
          end
          macs_pkg::PH_DRV_DN: begin
            drive = macs_pkg::DRIVE_DOWN;
            nxt   = macs_pkg::PH_WAIT_DN;
          end
          macs_pkg::PH_WAIT_DN: begin
            ctl.write   = chan_ok;
            ctl.advance = 1'b1;
            if (!chan_ok) begin
              channel_fault_next = 1'b1;
            end
            nxt = settled ? macs_pkg::PH_CAP_DN : macs_pkg::PH_WAIT_DN;
          end
          macs_pkg::PH_CAP_DN: begin
            if (chan_ok) begin
              captured_down_next = sample;
            end else begin
              channel_fault_next = 1'b1;
            end
            nxt = macs_pkg::PH_SETTLE;
          end
          default: begin
            nxt = macs_pkg::PH_FINISH;
          end
        endcase
        // timeout overrides the phase's own successor
        phase_next = expired ? macs_pkg::PH_FINISH : nxt;
      end else begin
        phase_next = phase;
      end
    end
  end

  always_comb begin
    result.phase_code    = macs_pkg::phase_code(phase_next);
    result.drive_request = drive;
    result.reading_up    = captured_up_next;
    result.reading_down  = captured_down_next;
    result.done_res      = finished_next;
    result.timeout_flag  = timed_out_next;
    result.channel_error = channel_fault_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= macs_pkg::PH_IDLE;
      tick_count    <= '0;
      captured_up   <= '0;
      captured_down <= '0;
      timed_out     <= 1'b0;
      channel_fault <= 1'b0;
      finished      <= 1'b0;
    end else begin
      phase         <= phase_next;
      tick_count    <= tick_next;
      captured_up   <= captured_up_next;
      captured_down <= captured_down_next;
      timed_out     <= timed_out_next;
      channel_fault <= channel_fault_next;
      finished      <= finished_next;
    end
  end

endmodule

FILE: hdl/motor_adc_settle_calibration_fsm.sv
// Top level of the motor ADC settle calibration sequencer: configuration
// registers, sequencer, history cell ring and output skid. Depends on macs_pkg.
//
// Each accepted input beat is one command (start or timer tick) and yields
// exactly one result beat. The whole step, including the four-entry masked
// settle compare along the history cell chain, completes in the cycle the
// beat is accepted, so the block takes one beat per clock while in_stall is
// low, and the result is registered. Results leave through a two-deep
// output register; in_stall rises only when both slots hold results that
// the downstream side has not taken. The user must write configuration
// registers through the plain write port while the block is idle; unenforced.
module motor_adc_settle_calibration_fsm (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  macs_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output macs_pkg::out_beat_t out_data,
  input  logic                cfg_write_en,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  localparam int N = macs_pkg::HISTORY_DEPTH;

  logic [3:0]                       channel_select;
  logic [macs_pkg::SAMPLE_BITS-1:0] precision_mask;
  logic [macs_pkg::COUNT_BITS-1:0]  timeout_ticks;

  logic                             step;
  macs_pkg::hist_ctl_t              ctl;
  macs_pkg::out_beat_t              result;
  logic [N-1:0]                     token;
  logic [N-1:0]                     eq;
  logic [macs_pkg::SAMPLE_BITS-1:0] mval [N];

  logic                             skid_valid;
  macs_pkg::out_beat_t              skid_data;
  logic                             pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_select <= macs_pkg::CHANNEL_SELECT_RST;
      precision_mask <= macs_pkg::PRECISION_MASK_RST;
      timeout_ticks  <= macs_pkg::TIMEOUT_TICKS_RST;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        macs_pkg::CFG_CHANNEL_SELECT: channel_select <= cfg_data[3:0];
        macs_pkg::CFG_PRECISION_MASK: precision_mask <= cfg_data[macs_pkg::SAMPLE_BITS-1:0];
        macs_pkg::CFG_TIMEOUT_TICKS:  timeout_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = skid_valid;
  assign step     = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  macs_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .beat           (in_data),
    .channel_select (channel_select),
    .timeout_ticks  (timeout_ticks),
    .settled        (eq[N-1]),
    .ctl            (ctl),
    .result         (result)
  );

  // ring of history cells; the write token walks from cell to cell
  for (genvar i = 0; i < N; i++) begin : g_cell
    macs_hist_cell #(
      .HOME (i == 0)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .mask     (precision_mask),
      .token_in (token[(i + N - 1) % N]),
      .ref_in   (mval[0]),
      .eq_in    ((i == 0) ? 1'b1 : eq[(i + N - 1) % N]),
      .token    (token[i]),
      .mval     (mval[i]),
      .eq_out   (eq[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      priority if (skid_valid) begin
        if (pop) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (step) begin
        if (!out_valid || pop) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (step) begin
      if (!out_valid || pop) begin
        out_data <= result;
      end else begin
        skid_data <= result;
      end
    end
  end

endmodule

FILE: hdl/macs_check.sv
// Port checker for motor_adc_settle_calibration_fsm and its bind statement.
// Watches the result channel only; depends on macs_pkg.
module macs_check (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input macs_pkg::out_beat_t out_data
);

  // hold a stalled result beat
  a_out_hold : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // done only once the sequence has dropped back to idle
  a_done_idle : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.done_res |->
      out_data.phase_code == macs_pkg::PHASE_CODE_IDLE)
    else $error("done set outside idle");

  // a timeout always leads to finish or idle
  a_timeout_end : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.timeout_flag |->
      out_data.phase_code == macs_pkg::PHASE_CODE_FINISH ||
      out_data.phase_code == macs_pkg::PHASE_CODE_IDLE)
    else $error("timeout flag set while sequence still running");

  // an up drive request hands over to its wait phase unless time ran out
  a_drive_up : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.drive_request == macs_pkg::DRIVE_UP |->
      out_data.phase_code == macs_pkg::PHASE_CODE_WAIT_UP ||
      out_data.phase_code == macs_pkg::PHASE_CODE_FINISH)
    else $error("drive up outside its phase");

endmodule

bind motor_adc_settle_calibration_fsm macs_check u_macs_check (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
